/* hw/rtl/sfr_pkg.sv */
// Shared constants, types and helpers for the stream find-and-replace block.
`default_nettype none

package sfr_pkg;

	localparam int MAX_PATTERN = 8;
	localparam int MAX_REPL    = 8;
	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 4;
	localparam int WORD_W      = 64;
	localparam int CFG_IDX_W   = 3;
	localparam int WIN_IDX_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int FILL_W      = $clog2(MAX_PATTERN + 1);
	localparam int REP_IDX_W   = $clog2(MAX_REPL);

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = CFG_IDX_W'(3);

	// Per-cell control from the sequencer.
	typedef struct packed {
		logic load;
		logic shift;
		logic clear;
	} cell_ctl_t;

	// A length of zero counts as one; anything above the top counts as the top.
	function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] raw,
		input logic [LEN_W-1:0] top);
		logic [LEN_W-1:0] res;
		if (raw == '0) begin
			res = LEN_W'(1);
		end else if (raw > top) begin
			res = top;
		end else begin
			res = raw;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/sfr_cell.sv */
// One window cell: holds a byte of the pending prefix and compares it to its pattern byte.
`default_nettype none

module sfr_cell (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire sfr_pkg::cell_ctl_t            ctl,
	input  wire logic [sfr_pkg::BYTE_W-1:0]    load_byte,
	input  wire logic [sfr_pkg::BYTE_W-1:0]    nb_byte,
	input  wire logic                          nb_valid,
	input  wire logic [sfr_pkg::BYTE_W-1:0]    pat_byte,
	output logic      [sfr_pkg::BYTE_W-1:0]    cell_byte,
	output logic                               cell_valid,
	output logic                               cell_match
);

	logic [sfr_pkg::BYTE_W-1:0] byte_q;
	logic                       valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.load) begin
			valid_q <= 1'b1;
		end else if (ctl.shift) begin
			valid_q <= nb_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			byte_q <= load_byte;
		end else if (ctl.shift) begin
			byte_q <= nb_byte;
		end
	end

	// An empty cell never breaks the prefix.
	assign cell_match = !valid_q || (byte_q == pat_byte);
	assign cell_byte  = byte_q;
	assign cell_valid = valid_q;

endmodule

`default_nettype wire

/* hw/rtl/stream_find_and_replace.sv */
// Top level of the stream find-and-replace block: config registers, cell row and sequencer.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    in_byte, end_of_stream
//   output    out_valid / out_ready  out_byte, run_last, stream_done
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A request is accepted in the idle state, checked while bytes that break the prefix drop out,
// then replaced, flushed at end of stream or passed straight to the closing finish state.
// Byte shifts all run through the row of window cells, one position per cycle while the output is free.
// A new request is taken only when the sequencer is back in its idle state.
// Output stalls freeze the sequencer outside its idle state; the last result waits in the output register.
// Reset clears the window, the sequencer and the registers to their defaults.
`default_nettype none

module stream_find_and_replace (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [sfr_pkg::BYTE_W-1:0]        in_byte,
	input  wire logic                              end_of_stream,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic      [sfr_pkg::BYTE_W-1:0]        out_byte,
	output logic                                   run_last,
	output logic                                   stream_done,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [sfr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [sfr_pkg::WORD_W-1:0]        cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_REPL,
		ST_FLUSH,
		ST_FINISH
	} state_t;

	state_t                              state_q;
	logic [sfr_pkg::WORD_W-1:0]          pattern_bytes_q;
	logic [sfr_pkg::LEN_W-1:0]           pattern_length_q;
	logic [sfr_pkg::WORD_W-1:0]          replacement_bytes_q;
	logic [sfr_pkg::LEN_W-1:0]           replacement_length_q;
	logic [sfr_pkg::FILL_W-1:0]          fill_q;
	logic                                eos_q;
	logic [sfr_pkg::REP_IDX_W-1:0]       rep_idx_q;
	logic [sfr_pkg::BYTE_W-1:0]          pend_q;
	logic                                pend_valid_q;
	logic                                out_valid_q;
	logic [sfr_pkg::BYTE_W-1:0]          out_byte_q;
	logic                                run_last_q;
	logic                                stream_done_q;

	logic [sfr_pkg::LEN_W-1:0]           plen;
	logic [sfr_pkg::LEN_W-1:0]           rlen;
	logic                                out_free;
	logic                                accept;
	logic                                prefix_ok;
	logic                                break_now;
	logic                                shift_en;
	logic                                clear_en;
	logic                                emit_en;
	logic                                finish_push;
	logic                                rep_last;
	logic [sfr_pkg::BYTE_W-1:0]          emit_byte;
	logic [sfr_pkg::BYTE_W-1:0]          repl_byte;

	sfr_pkg::cell_ctl_t                  cell_ctl   [sfr_pkg::MAX_PATTERN];
	logic [sfr_pkg::BYTE_W-1:0]          cell_byte  [sfr_pkg::MAX_PATTERN];
	logic [sfr_pkg::MAX_PATTERN-1:0]     cell_valid;
	logic [sfr_pkg::MAX_PATTERN-1:0]     cell_match;

	// Configuration registers; unknown indexes are ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_bytes_q      <= '0;
			pattern_length_q     <= sfr_pkg::LEN_W'(1);
			replacement_bytes_q  <= '0;
			replacement_length_q <= sfr_pkg::LEN_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				sfr_pkg::REG_PATTERN_BYTES:      pattern_bytes_q      <= cfg_data;
				sfr_pkg::REG_PATTERN_LENGTH:     pattern_length_q     <= cfg_data[sfr_pkg::LEN_W-1:0];
				sfr_pkg::REG_REPLACEMENT_BYTES:  replacement_bytes_q  <= cfg_data;
				sfr_pkg::REG_REPLACEMENT_LENGTH: replacement_length_q <= cfg_data[sfr_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign plen = sfr_pkg::clamp_len(pattern_length_q, sfr_pkg::LEN_W'(sfr_pkg::MAX_PATTERN));
	assign rlen = sfr_pkg::clamp_len(replacement_length_q, sfr_pkg::LEN_W'(sfr_pkg::MAX_REPL));

	// Window cell row; each cell shifts toward cell zero when a byte leaves.
	for (genvar i = 0; i < sfr_pkg::MAX_PATTERN; i++) begin : g_cell
		logic [sfr_pkg::BYTE_W-1:0] nb_byte;
		logic                       nb_valid;

		if (i == sfr_pkg::MAX_PATTERN - 1) begin : g_end
			assign nb_byte  = '0;
			assign nb_valid = 1'b0;
		end else begin : g_mid
			assign nb_byte  = cell_byte[i+1];
			assign nb_valid = cell_valid[i+1];
		end

		assign cell_ctl[i].load  = accept && (fill_q == sfr_pkg::FILL_W'(i));
		assign cell_ctl[i].shift = shift_en;
		assign cell_ctl[i].clear = clear_en;

		sfr_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (cell_ctl[i]),
			.load_byte  (in_byte),
			.nb_byte    (nb_byte),
			.nb_valid   (nb_valid),
			.pat_byte   (pattern_bytes_q[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W]),
			.cell_byte  (cell_byte[i]),
			.cell_valid (cell_valid[i]),
			.cell_match (cell_match[i])
		);
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	assign prefix_ok = (&cell_match) && (sfr_pkg::LEN_W'(fill_q) <= plen);
	assign break_now = (fill_q != '0) && !prefix_ok;
	assign rep_last  = (sfr_pkg::LEN_W'(rep_idx_q) == (rlen - sfr_pkg::LEN_W'(1)));
	assign repl_byte = replacement_bytes_q[rep_idx_q*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W];

	assign shift_en    = out_free && (((state_q == ST_CHECK) && break_now) ||
		(state_q == ST_FLUSH));
	assign clear_en    = out_free && (state_q == ST_REPL) && rep_last;
	assign emit_en     = shift_en || (out_free && (state_q == ST_REPL));
	assign emit_byte   = (state_q == ST_REPL) ? repl_byte : cell_byte[0];
	assign finish_push = out_free && (state_q == ST_FINISH) && pend_valid_q;

	// The newest emitted byte waits in a holding register until it is known
	// whether another byte of the same request follows it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			fill_q        <= '0;
			eos_q         <= 1'b0;
			rep_idx_q     <= '0;
			pend_valid_q  <= 1'b0;
			out_valid_q   <= 1'b0;
			run_last_q    <= 1'b0;
			stream_done_q <= 1'b0;
		end else begin
			if ((emit_en && pend_valid_q) || finish_push) begin
				out_valid_q   <= 1'b1;
				out_byte_q    <= pend_q;
				run_last_q    <= finish_push;
				stream_done_q <= finish_push && eos_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (emit_en) begin
				pend_q       <= emit_byte;
				pend_valid_q <= 1'b1;
			end else if (finish_push) begin
				pend_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fill_q  <= fill_q + sfr_pkg::FILL_W'(1);
						eos_q   <= end_of_stream;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (out_free) begin
						if (break_now) begin
							fill_q <= fill_q - sfr_pkg::FILL_W'(1);
						end else if (sfr_pkg::LEN_W'(fill_q) == plen) begin
							rep_idx_q <= '0;
							state_q   <= ST_REPL;
						end else if (eos_q && (fill_q != '0)) begin
							state_q <= ST_FLUSH;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_REPL: begin
					if (out_free) begin
						rep_idx_q <= rep_idx_q + sfr_pkg::REP_IDX_W'(1);
						if (rep_last) begin
							fill_q  <= '0;
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						fill_q <= fill_q - sfr_pkg::FILL_W'(1);
						if (fill_q == sfr_pkg::FILL_W'(1)) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign run_last    = run_last_q;
	assign stream_done = stream_done_q;

	a_fill_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == int'(fill_q))
		else $error("window fill count disagrees with valid cells");

	a_idle_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (int'(fill_q) < sfr_pkg::MAX_PATTERN))
		else $error("window full while waiting for a request");

	a_accept_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_CHECK))
		else $error("accepted request did not start the window check");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && stream_done_q) |-> run_last_q)
		else $error("stream end flagged on a byte that is not the last of its request");

	a_idle_nothing_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_valid_q)
		else $error("held byte left behind after a request finished");

endmodule

`default_nettype wire
